### rtl/shortest_job_first_ready_queue_assert.svh
// assertion macros used by the sjf ready queue datapath
// all macros sample on clk and are disabled while rst is high
`ifndef SHORTEST_JOB_FIRST_READY_QUEUE_ASSERT_SVH
`define SHORTEST_JOB_FIRST_READY_QUEUE_ASSERT_SVH

// same-cycle implication
`define SJFQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SJFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/sjfq_pkg.sv
// ----------------------------------------------------------------------------
// sjfq_pkg
// shared types and constants for the shortest-job-first ready queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sjfq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 16;
  localparam int BT_W        = 16;
  localparam int STATUS_W    = 2;
  localparam int ECNT_W      = 5;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic                capture;
    logic                exec;
    logic                insert;
    logic                remove;
    logic [STATUS_W-1:0] code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
  } stat_t;

endpackage

`default_nettype wire

### rtl/sjfq_if.sv
// ----------------------------------------------------------------------------
// sjfq request and response channels
// valid/ready channels carrying one queue request or one result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sjfq_req_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [sjfq_pkg::ID_W-1:0] job_id;
  logic [sjfq_pkg::BT_W-1:0] burst_time;

  modport source (output valid, output op, output job_id, output burst_time, input ready);
  modport sink   (input valid, input op, input job_id, input burst_time, output ready);
endinterface

interface sjfq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sjfq_pkg::STATUS_W-1:0] status;
  logic [sjfq_pkg::ID_W-1:0]     out_job_id;
  logic [sjfq_pkg::BT_W-1:0]     out_burst_time;
  logic [sjfq_pkg::ECNT_W-1:0]   entry_count;

  modport source (output valid, output status, output out_job_id, output out_burst_time,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input out_job_id, input out_burst_time,
                  input entry_count, output ready);
endinterface

`default_nettype wire

### rtl/sjfq_ctrl.sv
// ----------------------------------------------------------------------------
// sjfq_ctrl
// request sequencer and output word valid tracking
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sjfq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  input  wire sjfq_pkg::stat_t stat,
  output sjfq_pkg::cmd_t       cmd
);
  import sjfq_pkg::*;

  state_t state, state_next;
  logic   ovalid, ovalid_next;
  logic   can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
    end
  end

  // output register is free or being drained this cycle
  assign can_load  = !ovalid || rsp_ready;
  assign rsp_valid = ovalid;

  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    cmd         = '0;
    cmd.code    = ST_OK;
    ovalid_next = ovalid && !rsp_ready;
    unique case (state)
      S_IDLE: begin
        // no request word is taken while reset is held
        req_ready   = !rst;
        cmd.capture = req_valid && !rst;
        if (req_valid && !rst) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_load) begin
          cmd.exec    = 1'b1;
          ovalid_next = 1'b1;
          state_next  = S_IDLE;
          if (stat.is_pop) begin
            if (stat.empty) begin
              cmd.code = ST_EMPTY;
            end else begin
              cmd.remove = 1'b1;
            end
          end else begin
            if (stat.full) begin
              cmd.code = ST_FULL;
            end else begin
              cmd.insert = 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/sjfq_dp.sv
// ----------------------------------------------------------------------------
// sjfq_dp
// sorted slot array with parallel compare-and-shift, and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "shortest_job_first_ready_queue_assert.svh"

module sjfq_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire sjfq_pkg::cmd_t                cmd,
  input  wire logic                          op,
  input  wire logic [sjfq_pkg::ID_W-1:0]     job_id,
  input  wire logic [sjfq_pkg::BT_W-1:0]     burst_time,
  output sjfq_pkg::stat_t                    stat,
  output logic [sjfq_pkg::STATUS_W-1:0]      status,
  output logic [sjfq_pkg::ID_W-1:0]          out_job_id,
  output logic [sjfq_pkg::BT_W-1:0]          out_burst_time,
  output logic [sjfq_pkg::ECNT_W-1:0]        entry_count
);
  import sjfq_pkg::*;

  logic            op_q;
  logic [ID_W-1:0] id_q;
  logic [BT_W-1:0] bt_q;
  logic [CNT_W-1:0] count;

  logic [ID_W-1:0] slot_id [QUEUE_DEPTH];
  logic [BT_W-1:0] slot_bt [QUEUE_DEPTH];

  logic [QUEUE_DEPTH-1:0] longer;
  logic [CNT_W+ECNT_W-1:0] count_wide;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= op;
      id_q <= job_id;
      bt_q <= burst_time;
    end
  end

  assign stat.is_pop = (op_q == OP_POP);
  assign stat.full   = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty  = (count == '0);

  // held slots strictly longer than the new job; a suffix of the held range
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      longer[i] = (CNT_W'(i) < count) && (slot_bt[i] > bt_q);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd.insert) begin
        if (i > 0 && longer[(i > 0) ? i - 1 : 0]) begin
          slot_id[i] <= slot_id[(i > 0) ? i - 1 : 0];
          slot_bt[i] <= slot_bt[(i > 0) ? i - 1 : 0];
        end else if (longer[i] || CNT_W'(i) == count) begin
          slot_id[i] <= id_q;
          slot_bt[i] <= bt_q;
        end
      end else if (cmd.remove && i < QUEUE_DEPTH - 1) begin
        slot_id[i] <= slot_id[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        slot_bt[i] <= slot_bt[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.insert) begin
      count <= count + 1'b1;
    end else if (cmd.remove) begin
      count <= count - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status         <= cmd.code;
      out_job_id     <= cmd.remove ? slot_id[0] : '0;
      out_burst_time <= cmd.remove ? slot_bt[0] : '0;
    end
  end

  // count after the item, reported modulo 32
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      entry_count <= count_wide[ECNT_W-1:0];
    end
  end

  always_comb begin
    count_wide = {{ECNT_W{1'b0}}, count};
    if (cmd.insert) begin
      count_wide = {{ECNT_W{1'b0}}, count + 1'b1};
    end else if (cmd.remove) begin
      count_wide = {{ECNT_W{1'b0}}, count - 1'b1};
    end
  end

  `SJFQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(QUEUE_DEPTH), "count above depth")
  `SJFQ_ASSERT_NOW(a_insert_room, cmd.insert, !stat.full && !stat.is_pop, "insert without room")
  `SJFQ_ASSERT_NOW(a_remove_held, cmd.remove, !stat.empty && stat.is_pop, "remove from empty")
  `SJFQ_ASSERT_NEXT(a_push_count, cmd.insert, count == $past(count) + 1'b1, "push count slip")
  `SJFQ_ASSERT_NEXT(a_zero_payload, cmd.exec && !cmd.remove,
                    out_job_id == '0 && out_burst_time == '0, "payload not zero")

endmodule

`default_nettype wire

### rtl/shortest_job_first_ready_queue.sv
// result word: valid in the cycle after the exec cycle; exec waits until the output register is free or draining
// a new request is taken only in idle, after the previous one has been applied
//   by a single compare-and-shift over the slot array
// the next request is accepted while a result word waits in the output register
// reset: synchronous rst empties the queue and drops any pending result word
// ----------------------------------------------------------------------------
// shortest_job_first_ready_queue
// bounded ready queue sorted by burst time, push inserts and pop returns head
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shortest_job_first_ready_queue (
  input wire logic   clk,
  input wire logic   rst,
  sjfq_req_if.sink   req,
  sjfq_rsp_if.source rsp
);
  import sjfq_pkg::*;

  // command and status between sequencer and slot datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: idle takes a request word, exec applies it once the output
  // register is free or draining
  sjfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: each slot compares its key to the new burst time in parallel,
  // so an insert or a removal shifts all affected slots together; equal keys
  // are not shifted, keeping arrival order
  sjfq_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .op             (req.op),
    .job_id         (req.job_id),
    .burst_time     (req.burst_time),
    .stat           (stat),
    .status         (rsp.status),
    .out_job_id     (rsp.out_job_id),
    .out_burst_time (rsp.out_burst_time),
    .entry_count    (rsp.entry_count)
  );

endmodule

`default_nettype wire

### bench/tb_shortest_job_first_ready_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shortest_job_first_ready_queue
// self-checking bench for the sjf ready queue: a short directed table, then
// random push/pop traffic with a shadow sorted queue predicting every word,
// random idling on both channels, one long output stall and one full drain
// ----------------------------------------------------------------------------

module tb_shortest_job_first_ready_queue;
  import sjfq_pkg::*;

  localparam int RAND_ITEMS  = 820;
  localparam int CALM_TAIL   = 100;   // last items run with no idling
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AFTER  = 250;   // accepted requests before the long output stall
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_AT    = 500;   // random item where the sender waits for all results
  localparam int MAX_PRINTS  = 20;

  // one result word as the block reports it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     job_id;
    logic [BT_W-1:0]     burst_time;
    logic [ECNT_W-1:0]   entry_count;
  } done_word_t;

  // one request word, with an optional hand-typed result
  typedef struct packed {
    logic            op;
    logic [ID_W-1:0] job_id;
    logic [BT_W-1:0] burst_time;
    logic            typed;
    done_word_t      want;
  } job_req_t;

  // directed row: reps words, id counts up, burst moves by step each word
  typedef struct {
    logic            op;
    logic [ID_W-1:0] job_id;
    logic [BT_W-1:0] burst_time;
    int              reps;
    int              step;
    logic            typed;
    done_word_t      want;
  } dir_row_t;

  localparam int DIR_ROWS = 11;
  localparam done_word_t NO_WANT = '0;

  dir_row_t directed_rows [DIR_ROWS] = '{
    // pop from an empty queue right after reset, ignored fields nonzero
    '{OP_POP,  16'h1234, 16'h4321, 1,  0, 1'b1, '{ST_EMPTY, 16'h0, 16'h0, 5'd0}},
    // extreme id and burst
    '{OP_PUSH, 16'hffff, 16'hffff, 1,  0, 1'b1, '{ST_OK, 16'h0, 16'h0, 5'd1}},
    '{OP_PUSH, 16'h0000, 16'h0000, 1,  0, 1'b1, '{ST_OK, 16'h0, 16'h0, 5'd2}},
    // zero burst sorts ahead of the max burst
    '{OP_POP,  16'h0000, 16'h0000, 1,  0, 1'b1, '{ST_OK, 16'h0000, 16'h0000, 5'd1}},
    '{OP_POP,  16'h0000, 16'h0000, 1,  0, 1'b1, '{ST_OK, 16'hffff, 16'hffff, 5'd0}},
    '{OP_POP,  16'hffff, 16'hffff, 1,  0, 1'b1, '{ST_EMPTY, 16'h0, 16'h0, 5'd0}},
    // equal bursts leave in arrival order, a shorter one jumps ahead
    '{OP_PUSH, 16'h0011, 16'h0005, 3,  0, 1'b0, NO_WANT},
    '{OP_PUSH, 16'h0020, 16'h0004, 1,  0, 1'b0, NO_WANT},
    '{OP_POP,  16'h0000, 16'h0000, 4,  0, 1'b0, NO_WANT},
    // fill with falling bursts, every insert shifts the whole array
    '{OP_PUSH, 16'h0100, 16'hffff, 16, -1, 1'b0, NO_WANT},
    // push to a full queue
    '{OP_PUSH, 16'h5555, 16'haaaa, 1,  0, 1'b1, '{ST_FULL, 16'h0, 16'h0, 5'd16}}
  };

  logic clk;
  logic rst;

  sjfq_req_if req_ch ();
  sjfq_rsp_if rsp_ch ();

  shortest_job_first_ready_queue u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow of the sorted slot array
  logic [ID_W-1:0] shadow_ids    [QUEUE_DEPTH];
  logic [BT_W-1:0] shadow_bursts [QUEUE_DEPTH];
  int              shadow_count;

  done_word_t awaited_results [$];
  job_req_t   offered;            // word currently on the request channel
  logic       calm;               // no idling on either side
  int         mismatches;
  int         accepted_reqs;
  int         cycle_count;
  int         pushes_ok, pops_ok, refused_full, refused_empty, peak_fill;

  // sorted insert behind equal bursts, head removal, refusals leave state alone
  function automatic done_word_t apply_job_request(job_req_t j);
    done_word_t w;
    int         pos;
    w = '0;
    w.status = ST_OK;
    if (j.op == OP_PUSH) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        w.status = ST_FULL;
      end else begin
        pos = shadow_count;
        while (pos > 0 && shadow_bursts[pos-1] > j.burst_time) begin
          shadow_ids[pos]    = shadow_ids[pos-1];
          shadow_bursts[pos] = shadow_bursts[pos-1];
          pos--;
        end
        shadow_ids[pos]    = j.job_id;
        shadow_bursts[pos] = j.burst_time;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        w.status = ST_EMPTY;
      end else begin
        w.job_id     = shadow_ids[0];
        w.burst_time = shadow_bursts[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_ids[i-1]    = shadow_ids[i];
          shadow_bursts[i-1] = shadow_bursts[i];
        end
        shadow_count--;
      end
    end
    w.entry_count = shadow_count[ECNT_W-1:0];
    return w;
  endfunction

  task automatic note_mismatch(string msg);
    if (mismatches < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // random request; push share depends on mode so the queue swings full and empty
  function automatic job_req_t make_random_job(int mode);
    job_req_t j;
    int       push_pct;
    int       pick;
    j = '0;
    push_pct = (mode == 0) ? 50 : (mode == 1) ? 80 : 25;
    j.op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
    j.job_id = ID_W'($urandom);
    pick = $urandom_range(0, 9);
    if (pick <= 3) begin
      j.burst_time = BT_W'($urandom_range(0, 7));    // narrow range, lots of ties
    end else if (pick == 4) begin
      j.burst_time = '0;
    end else if (pick == 5) begin
      j.burst_time = '1;
    end else begin
      j.burst_time = BT_W'($urandom);
    end
    return j;
  endfunction

  // hold the word until the handshake, valid stays high afterwards
  task automatic offer_job(job_req_t j);
    req_ch.valid      <= 1'b1;
    req_ch.op         <= j.op;
    req_ch.job_id     <= j.job_id;
    req_ch.burst_time <= j.burst_time;
    offered           <= j;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic sender_gap(int n);
    req_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      sender_gap($urandom_range(1, 12));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_shortest_job_first_ready_queue: FAIL");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off after HOLD_AFTER accepted requests
  initial begin : result_sink
    bit held;
    held = 1'b0;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && accepted_reqs >= HOLD_AFTER) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // both handshakes sampled at the edge; result checked before the new request
  always @(posedge clk) begin
    done_word_t got;
    done_word_t want;
    done_word_t pred;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.status, rsp_ch.out_job_id, rsp_ch.out_burst_time,
                rsp_ch.entry_count};
        if (awaited_results.size() == 0) begin
          note_mismatch($sformatf("result word with nothing awaited: %h", got));
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status)
            note_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.job_id !== want.job_id)
            note_mismatch($sformatf("job id %h, want %h", got.job_id, want.job_id));
          if (got.burst_time !== want.burst_time)
            note_mismatch($sformatf("burst %h, want %h", got.burst_time, want.burst_time));
          if (got.entry_count !== want.entry_count)
            note_mismatch($sformatf("entry count %0d, want %0d",
                                    got.entry_count, want.entry_count));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        pred = apply_job_request(offered);
        awaited_results.push_back(offered.typed ? offered.want : pred);
        accepted_reqs++;
        case (pred.status)
          ST_FULL:  refused_full++;
          ST_EMPTY: refused_empty++;
          default: begin
            if (offered.op == OP_PUSH) pushes_ok++;
            else pops_ok++;
          end
        endcase
        if (shadow_count > peak_fill) peak_fill = shadow_count;
      end
    end
  end

  initial begin : stimulus
    job_req_t j;
    int       mode;
    int       drain_cycles;
    rst = 1'b1;
    calm = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_PUSH;
    req_ch.job_id = '0;
    req_ch.burst_time = '0;
    offered = '0;
    shadow_count = 0;
    mismatches = 0;
    accepted_reqs = 0;
    cycle_count = 0;
    pushes_ok = 0;
    pops_ok = 0;
    refused_full = 0;
    refused_empty = 0;
    peak_fill = 0;
    mode = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        j.op         = directed_rows[r].op;
        j.job_id     = directed_rows[r].job_id + ID_W'(k);
        j.burst_time = directed_rows[r].burst_time + BT_W'(k * directed_rows[r].step);
        j.typed      = directed_rows[r].typed;
        j.want       = directed_rows[r].want;
        maybe_sender_gap();
        offer_job(j);
      end
    end

    // random traffic, starts from a full queue
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) mode = $urandom_range(0, 2);
      calm = (n >= 400 && n < 470) || (n >= RAND_ITEMS - CALM_TAIL);
      if (n == DRAIN_AT) begin
        // stop offering until every owed result word is back
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0) @(posedge clk);
      end
      maybe_sender_gap();
      offer_job(make_random_job(mode));
    end
    req_ch.valid <= 1'b0;

    drain_cycles = 0;
    while (awaited_results.size() != 0 && drain_cycles < 2000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    if (awaited_results.size() != 0)
      note_mismatch($sformatf("%0d result words never arrived", awaited_results.size()));

    $display("covered %0d requests: %0d pushes, %0d pops, %0d refused full, %0d refused empty",
             accepted_reqs, pushes_ok, pops_ok, refused_full, refused_empty);
    $display("peak fill %0d of %0d, %0d mismatches", peak_fill, QUEUE_DEPTH, mismatches);
    if (mismatches == 0) begin
      $display("tb_shortest_job_first_ready_queue: PASS");
    end else begin
      $display("tb_shortest_job_first_ready_queue: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/sjfq_pkg.sv
rtl/sjfq_if.sv
rtl/sjfq_ctrl.sv
rtl/sjfq_dp.sv
rtl/shortest_job_first_ready_queue.sv
bench/tb_shortest_job_first_ready_queue.sv
